>>> hw/rtl/fdack_pkg.sv
package fdack_pkg;

  localparam int HDR_LEN            = 12;
  localparam int LENGTH_COUNT_WIDTH = 21;
  localparam int QUEUE_DEPTH        = 2;
  localparam int CFG_INDEX_WIDTH    = 4;
  localparam int CFG_DATA_WIDTH     = 21;

  localparam logic [7:0]  START_BYTE     = 8'hFF;
  localparam logic [31:0] HDR_TAG        = 32'hFFACCE56;
  localparam logic [15:0] SEQ_RESET      = 16'hFFF0;
  localparam logic [15:0] LAG_THR_RESET  = 16'd10;
  localparam logic [20:0] MAX_PAY_RESET  = 21'd1048576;

  typedef enum logic {
    CMD_RX   = 1'b0,
    CMD_SEND = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_TRUNC   = 2'd2,
    KIND_SEND    = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LAG_THRESHOLD = 4'd0,
    REG_MAX_PAYLOAD   = 4'd1
  } reg_idx_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
    logic       is_start;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [15:0] sequence_res;
    logic [15:0] unacked;
    logic        lag_warning;
    logic        lagging;
  } result_t;

endpackage

>>> hw/rtl/fdack_front.sv
module fdack_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_rx_byte,
  output logic              push,
  output fdack_pkg::item_t  push_item,
  input  logic              q_ready
);
  import fdack_pkg::*;

  logic  fr_v_r, fr_v_nxt;
  item_t fr_item_r;

  assign in_ready  = !fr_v_r || q_ready;
  assign push      = fr_v_r && q_ready;
  assign push_item = fr_item_r;

  always_comb begin
    fr_v_nxt = fr_v_r;
    if (in_valid && in_ready) begin
      fr_v_nxt = 1'b1;
    end else if (q_ready) begin
      fr_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_item_r.cmd      <= cmd_t'(in_cmd);
      fr_item_r.rx_byte  <= in_rx_byte;
      fr_item_r.is_start <= (in_rx_byte == START_BYTE);
    end
  end

endmodule

>>> hw/rtl/fdack_queue.sv
module fdack_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fdack_pkg::item_t  push_item,
  output logic              q_ready,
  output logic              q_valid,
  output fdack_pkg::item_t  q_item,
  input  logic              pop
);
  import fdack_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t          mem [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PW'(1);
    end
  endfunction

  assign q_ready = (count_r != CW'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> hw/rtl/fdack_back.sv
module fdack_back #(
  parameter int LENGTH_COUNT_WIDTH = fdack_pkg::LENGTH_COUNT_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  fdack_pkg::item_t                      q_item,
  output logic                                  pop,
  input  logic                                  cfg_valid,
  input  logic [fdack_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [fdack_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output logic                                  res_valid,
  output fdack_pkg::result_t                    res,
  input  logic                                  res_ready
);
  import fdack_pkg::*;

  localparam int W = LENGTH_COUNT_WIDTH;

  logic [15:0]  lag_thr_r;
  logic [20:0]  max_pay_r;

  logic         in_payload_r, in_payload_nxt;
  logic [3:0]   fill_r, fill_nxt;
  logic [W-1:0] left_r, left_nxt;
  logic [15:0]  rx_seq_r, rx_seq_nxt;
  logic [15:0]  send_seq_r, send_seq_nxt;
  logic [15:0]  acked_r, acked_nxt;
  logic [7:0]   hw_r   [HDR_LEN];
  logic [7:0]   hw_nxt [HDR_LEN];
  logic [7:0]   win    [HDR_LEN];

  logic         out_v_r, out_v_nxt;
  result_t      out_r, out_nxt;
  logic         has_res;

  logic [15:0]  hdr_lo, hdr_hi, hdr_seq;
  logic [31:0]  hdr_size;
  logic         tag_ok, len_ok;
  logic         drop_found;
  logic [3:0]   drop_idx;
  logic [4:0]   shift_idx [HDR_LEN];
  logic [W-1:0] left_dec;
  logic [15:0]  send_inc, una_send;

  assign pop       = q_valid && (!out_v_r || res_ready);
  assign res_valid = out_v_r;
  assign res       = out_r;

  // Header view with the incoming byte in the last slot
  always_comb begin
    for (int k = 0; k < HDR_LEN; k++) begin
      win[k] = hw_r[k];
    end
    win[HDR_LEN-1] = q_item.rx_byte;
  end

  assign hdr_lo   = {win[5], win[4]};
  assign hdr_hi   = {win[7], win[6]};
  assign hdr_seq  = {hdr_hi[11:0], 4'b0000} | {4'b0000, hdr_lo[15:4]};
  assign hdr_size = {win[11], win[10], win[9], win[8]};
  assign tag_ok   = ({win[0], win[1], win[2], win[3]} == HDR_TAG);
  assign len_ok   = tag_ok && (hdr_size >= 32'd2) && (hdr_size[31:21] == '0)
                    && (hdr_size[20:0] <= max_pay_r);

  // lowest start byte among window bytes 1..11
  always_comb begin
    drop_found = 1'b0;
    drop_idx   = '0;
    for (int k = HDR_LEN - 1; k >= 1; k--) begin
      if (win[k] == START_BYTE) begin
        drop_found = 1'b1;
        drop_idx   = 4'(k);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < HDR_LEN; k++) begin
      shift_idx[k] = 5'(k) + {1'b0, drop_idx};
    end
  end

  assign left_dec = left_r - W'(1);
  assign send_inc = send_seq_r + 16'd1;
  assign una_send = send_inc - acked_r;

  always_comb begin
    in_payload_nxt = in_payload_r;
    fill_nxt       = fill_r;
    left_nxt       = left_r;
    rx_seq_nxt     = rx_seq_r;
    send_seq_nxt   = send_seq_r;
    acked_nxt      = acked_r;
    for (int k = 0; k < HDR_LEN; k++) begin
      hw_nxt[k] = hw_r[k];
    end
    has_res = 1'b0;
    out_nxt = '0;

    if (pop) begin
      if (q_item.cmd == CMD_SEND) begin
        send_seq_nxt        = send_inc;
        has_res             = 1'b1;
        out_nxt.kind        = KIND_SEND;
        out_nxt.sequence_res = send_inc;
        out_nxt.unacked     = una_send;
        out_nxt.lag_warning = (una_send >= (lag_thr_r >> 1));
        out_nxt.lagging     = (una_send >= lag_thr_r);
      end else if (in_payload_r) begin
        has_res              = 1'b1;
        out_nxt.sequence_res = rx_seq_r;
        if (q_item.is_start) begin
          // start byte mid-message: abandon it and open a new window
          in_payload_nxt = 1'b0;
          left_nxt       = '0;
          hw_nxt[0]      = START_BYTE;
          fill_nxt       = 4'd1;
          out_nxt.kind   = KIND_TRUNC;
        end else begin
          left_nxt          = left_dec;
          out_nxt.kind      = KIND_PAYLOAD;
          out_nxt.data_byte = q_item.rx_byte;
          if (left_dec == '0) begin
            in_payload_nxt = 1'b0;
            out_nxt.last   = 1'b1;
          end
        end
      end else if (fill_r == '0 && !q_item.is_start) begin
        // junk while hunting
      end else if (fill_r >= 4'(HDR_LEN)) begin
        fill_nxt = '0;
      end else if (fill_r != 4'(HDR_LEN - 1)) begin
        hw_nxt[fill_r] = q_item.rx_byte;
        fill_nxt       = fill_r + 4'd1;
      end else if (tag_ok && hdr_size == '0) begin
        acked_nxt            = hdr_seq;
        fill_nxt             = '0;
        has_res              = 1'b1;
        out_nxt.kind         = KIND_ACK;
        out_nxt.sequence_res = hdr_seq;
        out_nxt.unacked      = send_seq_r - hdr_seq;
      end else if (len_ok) begin
        rx_seq_nxt     = hdr_seq;
        left_nxt       = hdr_size[W-1:0];
        in_payload_nxt = 1'b1;
        fill_nxt       = '0;
      end else if (drop_found) begin
        for (int k = 0; k < HDR_LEN; k++) begin
          if (shift_idx[k] < 5'(HDR_LEN)) begin
            hw_nxt[k] = win[shift_idx[k][3:0]];
          end
        end
        fill_nxt = 4'(HDR_LEN) - drop_idx;
      end else begin
        fill_nxt = '0;
      end
    end
  end

  always_comb begin
    if (pop) begin
      out_v_nxt = has_res;
    end else if (res_ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_thr_r    <= LAG_THR_RESET;
      max_pay_r    <= MAX_PAY_RESET;
      in_payload_r <= 1'b0;
      fill_r       <= '0;
      left_r       <= '0;
      rx_seq_r     <= '0;
      send_seq_r   <= SEQ_RESET;
      acked_r      <= SEQ_RESET;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_LAG_THRESHOLD: lag_thr_r <= cfg_data[15:0];
          REG_MAX_PAYLOAD:   max_pay_r <= cfg_data[20:0];
          default: ;
        endcase
      end
      in_payload_r <= in_payload_nxt;
      fill_r       <= fill_nxt;
      left_r       <= left_nxt;
      rx_seq_r     <= rx_seq_nxt;
      send_seq_r   <= send_seq_nxt;
      acked_r      <= acked_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < HDR_LEN; k++) begin
      hw_r[k] <= hw_nxt[k];
    end
    if (pop && has_res) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> hw/rtl/frame_deframer_with_ack_tracking.sv
// Channel   Handshake               Payload
// in_       in_valid / in_ready     in_cmd, in_rx_byte
// out_      out_valid / out_ready   out_kind, out_data_byte, out_last, out_sequence_res,
//                                   out_unacked, out_lag_warning, out_lagging
// cfg_      cfg_valid / cfg_ready   cfg_index, cfg_data (cfg_ready is always high)
//
// One item per cycle sustained while out_ready is high; the back end judges a full header
// as its last byte pops. For an item with a result, out_valid rises as the result register
// loads when the item pops, after the input register, then the two-entry queue.
// Synchronous active-low reset; no clearing pass, the header window needs none.
// A stalled output holds the back end; the queue and input register absorb up to three
// more items before in_ready drops.
module frame_deframer_with_ack_tracking #(
  parameter int LENGTH_COUNT_WIDTH = fdack_pkg::LENGTH_COUNT_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_cmd,
  input  logic [7:0]                            in_rx_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_kind,
  output logic [7:0]                            out_data_byte,
  output logic                                  out_last,
  output logic [15:0]                           out_sequence_res,
  output logic [15:0]                           out_unacked,
  output logic                                  out_lag_warning,
  output logic                                  out_lagging,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fdack_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [fdack_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import fdack_pkg::*;

  logic    push, q_ready, q_valid, pop;
  item_t   push_item, q_item;
  result_t res;

  assign cfg_ready = 1'b1;

  fdack_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .in_rx_byte(in_rx_byte),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready)
  );

  fdack_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop)
  );

  fdack_back #(
    .LENGTH_COUNT_WIDTH(LENGTH_COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .res_valid(out_valid),
    .res      (res),
    .res_ready(out_ready)
  );

  assign out_kind         = res.kind;
  assign out_data_byte    = res.data_byte;
  assign out_last         = res.last;
  assign out_sequence_res = res.sequence_res;
  assign out_unacked      = res.unacked;
  assign out_lag_warning  = res.lag_warning;
  assign out_lagging      = res.lagging;

endmodule
